### design/dq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// No dependencies; dq_ctrl, dq_dp and bounded_deque_with_search import this package.
package dq_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = 7;
   localparam int SUM_BITS  = CNT_BITS + 1;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_SEARCH     = 3'd4;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [2:0]          cmd;
      logic signed [31:0]  value;
      logic [6:0]          count;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [6:0] removed;
      logic [6:0] occupancy;
      logic       status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;         // perform a push, pop or no-op directly and respond
      logic scan_load;    // start a search walk
      logic scan_run;     // walk in progress
      logic scan_finish;  // capture the search response
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic scan_done;
   } dp_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

### design/dq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dq_ctrl.sv
// Controller for the queue: accepts commands and sequences the search walk.
// Depends on dq_pkg.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_cmd,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd,
   output logic        busy
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_SEARCH && !dp_stat.empty) begin
                  dp_cmd.scan_load = 1'b1;
                  state_in         = ST_SCAN;
               end else begin
                  dp_cmd.exec = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            dp_cmd.scan_run = 1'b1;
            if (dp_stat.scan_done) begin
               dp_cmd.scan_finish = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### design/dq_dp.sv
// Datapath: ring indices, fill level, entry RAM, search walk and response register.
// Depends on dq_pkg and dq_ram.
module dq_dp
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  dp_cmd,
   input  req_type     req_item,
   output dp_stat_type dp_stat,
   output rsp_type     rsp_item,
   output logic        rsp_valid
);

   logic [IDX_BITS-1:0]  front_ff, front_in;
   logic [IDX_BITS-1:0]  back_ff, back_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic [IDX_BITS-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [CNT_BITS-1:0]  scan_left_ff, scan_left_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [WORD_BITS-1:0] key_ff, key_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] rd_data;
   logic [IDX_BITS-1:0]  front_prev, back_next, scan_next;
   logic [CNT_BITS-1:0]  clamped;
   logic [SUM_BITS-1:0]  front_sum, back_diff;
   logic                 full, is_push, scan_rd, hit;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;

   assign word    = req_item.value[WORD_BITS-1:0];
   assign full    = (fill_ff == CNT_BITS'(DEPTH));
   assign is_push = req_item.cmd inside {CMD_PUSH_FRONT, CMD_PUSH_BACK};

   assign front_prev = (front_ff == '0) ? IDX_BITS'(DEPTH - 1) : front_ff - 1'b1;
   assign back_next  = (back_ff == IDX_BITS'(DEPTH - 1)) ? '0 : back_ff + 1'b1;
   assign scan_next  = (scan_ptr_ff == IDX_BITS'(DEPTH - 1)) ? '0 : scan_ptr_ff + 1'b1;

   assign clamped = (req_item.count < fill_ff) ? req_item.count : fill_ff;

   // Removal never exceeds the depth, so one conditional subtract wraps the ring.
   always_comb begin
      front_sum = SUM_BITS'(front_ff) + SUM_BITS'(clamped);
      if (front_sum >= SUM_BITS'(DEPTH)) begin
         front_sum = front_sum - SUM_BITS'(DEPTH);
      end
      back_diff = SUM_BITS'(back_ff) + SUM_BITS'(DEPTH) - SUM_BITS'(clamped);
      if (back_diff >= SUM_BITS'(DEPTH)) begin
         back_diff = back_diff - SUM_BITS'(DEPTH);
      end
   end

   assign wr_en   = dp_cmd.exec && is_push && !full;
   assign wr_addr = (req_item.cmd == CMD_PUSH_FRONT) ? front_prev : back_ff;

   assign scan_rd = dp_cmd.scan_run && (scan_left_ff != '0);
   assign hit     = cmp_valid_ff && (rd_data == key_ff);

   assign dp_stat.empty     = (fill_ff == '0);
   assign dp_stat.scan_done = hit || (cmp_valid_ff && scan_left_ff == '0);

   dq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (scan_rd),
      .rd_addr (scan_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      fill_in      = fill_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      cmp_valid_in = 1'b0;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      if (dp_cmd.exec) begin
         rsp_valid_in     = 1'b1;
         rsp_in           = '0;
         rsp_in.status    = STATUS_OK;
         case (req_item.cmd)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  front_in = front_prev;
                  fill_in  = fill_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  back_in = back_next;
                  fill_in = fill_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               front_in       = front_sum[IDX_BITS-1:0];
               fill_in        = fill_ff - clamped;
               rsp_in.removed = clamped;
            end
            CMD_POP_BACK: begin
               back_in        = back_diff[IDX_BITS-1:0];
               fill_in        = fill_ff - clamped;
               rsp_in.removed = clamped;
            end
            default: begin
               // search on an empty store and undefined codes change nothing
            end
         endcase
         rsp_in.occupancy = fill_in;
      end

      if (dp_cmd.scan_load) begin
         scan_ptr_in  = front_ff;
         scan_left_in = fill_ff;
         key_in       = word;
      end

      // Issue one read per cycle; compare the registered read data in the next cycle.
      if (scan_rd) begin
         scan_ptr_in  = scan_next;
         scan_left_in = scan_left_ff - 1'b1;
         cmp_valid_in = 1'b1;
      end

      if (dp_cmd.scan_finish) begin
         rsp_valid_in     = 1'b1;
         rsp_in           = '0;
         rsp_in.found     = hit;
         rsp_in.occupancy = fill_ff;
         rsp_in.status    = STATUS_OK;
         cmp_valid_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      key_ff       <= key_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/bounded_deque_with_search.sv
// Bounded double-ended queue of signed words with a linear search.
// Usage:
//   Command channel: drive req_item and raise start; the command transfers at
//   a rising edge where start is high and busy is low. cmd selects push front,
//   push back, pop front, pop back (count entries, clamped to occupancy) or
//   search for value.
//   Response channel: every command yields exactly one response, shown on
//   rsp_item for one cycle while rsp_valid is high. The receiver cannot stall;
//   the response must be taken in that cycle.
//   Latency: pushes, pops, undefined codes and a search of an empty queue
//   respond in the cycle after the transfer, and busy stays low, so one such
//   command can transfer every cycle.
//   A search walks the entry RAM from the front, one entry per cycle through
//   its single registered read port. It holds busy high until it responds,
//   after comparing entries up to the first match or up to the occupancy
//   (at most 64) when there is none; the next command can transfer in the
//   cycle the response is shown.
//   Reset (synchronous, active high) empties the queue; stored words are
//   left as they are and are never read before being written again.
//   A push into a full queue drops the word and reports status full.
// Depends on dq_pkg, dq_ctrl, dq_dp, dq_ram.
module bounded_deque_with_search
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   dq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_item.cmd),
      .dp_stat (dp_stat),
      .dp_cmd  (dp_cmd),
      .busy    (busy)
   );

   dq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_item  (req_item),
      .dp_stat   (dp_stat),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

   a_single_cycle_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd != CMD_SEARCH) |=> rsp_valid)
      else $error("single-cycle command produced no response");

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.occupancy <= CNT_BITS'(DEPTH)))
      else $error("occupancy beyond depth");

   a_full_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_FULL) |->
         (rsp_item.removed == '0 && !rsp_item.found
          && rsp_item.occupancy == CNT_BITS'(DEPTH)))
      else $error("dropped push reported with inconsistent fields");

   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.scan_load |=> (busy && !rsp_valid))
      else $error("search walk did not hold busy");

endmodule
